@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the bitmap rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap assertion failed");

// antecedent implies consequent in the next cycle
`define BMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap assertion failed");

`endif

@@ hw/rtl/bmr_pkg.sv @@
// shared types and constants for the bitmap range set/clear/test block
package bmr_pkg;

  localparam int MAX_BITS    = 4096;
  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BIT_W       = 12;
  localparam int LEN_W       = 13;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 2;

  localparam logic [LEN_W-1:0]   BITS_IN_USE_RST = LEN_W'(MAX_BITS);
  localparam logic [PADDR_W-1:0] ADDR_BITS_IN_USE = '0;

  // operation codes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TEST  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_DONE
  } bmr_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mod;
    logic clr_step;
    logic out_load;
  } bmr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_bad;
    logic last_byte;
    logic test_fail;
    logic clr_last;
  } bmr_sts_t;

endpackage

@@ hw/rtl/bmr_ram.sv @@
// generic simple dual-port ram with registered read
module bmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bmr_dpath.sv @@
// datapath: request registers, byte mask, read-modify-write and result register
module bmr_dpath
  import bmr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bmr_cmd_t         cmd,
  output bmr_sts_t         sts,
  input  logic [1:0]       in_func,
  input  logic [BIT_W-1:0] in_first_bit,
  input  logic [BIT_W-1:0] in_last_bit,
  input  logic [LEN_W-1:0] bits_in_use,
  output logic             out_status
);

`include "assert_macros.svh"

  logic [1:0]        func_r;
  logic [BIT_W-1:0]  first_r;
  logic [BIT_W-1:0]  last_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              res_r, res_nxt;
  logic              out_status_r;

  logic [LEN_W-1:0]  limit;
  logic              func_ok;
  logic              req_bad;
  logic [ADDR_W-1:0] first_byte, last_byte;
  logic [2:0]        lo, hi;
  logic [7:0]        mask;
  logic [7:0]        rd_data;
  logic [7:0]        mod_data;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  // request check against the length in use
  always_comb begin
    limit   = (bits_in_use > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : bits_in_use;
    func_ok = (in_func == OP_SET) || (in_func == OP_CLEAR) || (in_func == OP_TEST);
    req_bad = ({1'b0, in_last_bit} >= limit) || (in_first_bit > in_last_bit) ||
              !func_ok;
  end

  // byte mask for the current byte, position 0 is the msb
  always_comb begin
    first_byte = first_r[BIT_W-1:3];
    last_byte  = last_r[BIT_W-1:3];
    lo = (addr_r == first_byte) ? first_r[2:0] : 3'd0;
    hi = (addr_r == last_byte)  ? last_r[2:0]  : 3'd7;
    for (int j = 0; j < 8; j++) begin
      mask[3'(7 - j)] = (3'(j) >= lo) && (3'(j) <= hi);
    end
  end

  // modify step
  always_comb begin
    case (func_r)
      OP_SET:   mod_data = rd_data | mask;
      OP_CLEAR: mod_data = rd_data & ~mask;
      default:  mod_data = rd_data;
    endcase
  end

  // status to the controller
  always_comb begin
    sts.req_bad   = req_bad;
    sts.test_fail = (func_r == OP_TEST) && ((rd_data & mask) != mask);
    sts.last_byte = (addr_r == last_byte);
    sts.clr_last  = (addr_r == ADDR_W'(STORE_BYTES - 1));
  end

  // store write and read ports
  always_comb begin
    wr_en   = cmd.clr_step || (cmd.mod && (func_r != OP_TEST));
    wr_data = cmd.clr_step ? 8'h00 : mod_data;
    rd_addr = cmd.load ? in_first_bit[BIT_W-1:3] : addr_r + 1'b1;
  end

  // byte walk address and result flag
  always_comb begin
    addr_nxt = addr_r;
    res_nxt  = res_r;
    if (cmd.load) begin
      addr_nxt = in_first_bit[BIT_W-1:3];
      res_nxt  = sts.req_bad;
    end else if (cmd.mod || cmd.clr_step) begin
      addr_nxt = addr_r + 1'b1;
      if (cmd.mod && sts.test_fail) begin
        res_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      res_r  <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      res_r  <= res_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      first_r <= in_first_bit;
      last_r  <= in_last_bit;
    end
    if (cmd.out_load) begin
      out_status_r <= res_r;
    end
  end

  bmr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_r),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_status = out_status_r;

  // the walk never passes the last byte of the range
  `BMR_ASSERT_NOW(a_walk_in_range, cmd.mod, addr_r <= last_byte)

endmodule

@@ hw/rtl/bmr_ctrl.sv @@
// controller: clearing pass, request sequencing and result handshake
module bmr_ctrl
  import bmr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bmr_cmd_t cmd,
  input  bmr_sts_t sts
);

`include "assert_macros.svh"

  bmr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.req_bad ? ST_DONE : ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod = 1'b1;
        if (sts.test_fail || sts.last_byte) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  // an accepted transaction goes straight to the walk or to the result
  `BMR_ASSERT_NEXT(a_accept_next, in_valid && in_ready,
                   state_r == ST_MOD || state_r == ST_DONE)
  // a finished result waits while the previous one is still held
  `BMR_ASSERT_NEXT(a_done_holds, state_r == ST_DONE && out_valid_r && !out_ready,
                   state_r == ST_DONE)
  // a new result is always presented after it is loaded
  `BMR_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_r && state_r == ST_IDLE)

endmodule

@@ hw/rtl/bitmap_range_set_clear_test.sv @@
// Bit array of up to 4096 positions (position 0 is the msb of byte 0) with set, clear and
// test over an inclusive range. After reset the block runs a clearing pass over all 512 store
// bytes, one store byte per cycle, during which in_ready stays low; configuration writes are
// taken throughout. A good request is accepted in ST_IDLE, then ST_MOD works each store byte
// that the range touches (a pipelined read-modify-write on the byte store, one byte per
// cycle), then ST_DONE loads the result once the result register is free. A bad range or
// unknown operation goes from the accept straight to ST_DONE. A test stops at the first
// byte with a clear bit. One request is worked at a time; the result register lets the next
// transaction be accepted while a result still waits.
module bitmap_range_set_clear_test
  import bmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [BIT_W-1:0]   in_first_bit,
  input  logic [BIT_W-1:0]   in_last_bit,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  bmr_cmd_t         cmd;
  bmr_sts_t         sts;
  logic [LEN_W-1:0] bits_in_use_r, bits_in_use_nxt;

  // bits_in_use register
  always_comb begin
    bits_in_use_nxt = bits_in_use_r;
    if (psel && penable && pwrite && (paddr == ADDR_BITS_IN_USE)) begin
      bits_in_use_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= BITS_IN_USE_RST;
    end else begin
      bits_in_use_r <= bits_in_use_nxt;
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_BITS_IN_USE) begin
      prdata = {{(DATA_W-LEN_W){1'b0}}, bits_in_use_r};
    end
  end

  assign pready = 1'b1;

  bmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bmr_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_func),
    .in_first_bit (in_first_bit),
    .in_last_bit  (in_last_bit),
    .bits_in_use  (bits_in_use_r),
    .out_status   (out_status)
  );

endmodule

@@ test/bitmap_range_set_clear_test_tb.sv @@
// self-checking testbench for the bitmap range set/clear/test block
module bitmap_range_set_clear_test_tb;
  import bmr_pkg::*;

  // func value with no defined operation
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 125;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = OP_SET;
  logic [BIT_W-1:0]   in_first_bit = '0;
  logic [BIT_W-1:0]   in_last_bit = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // shadow of the bit array and of the length register
  logic [0:MAX_BITS-1] shadow_bits = '0;
  logic [LEN_W-1:0]    shadow_len = BITS_IN_USE_RST;

  logic expected_status[$];
  int   err_count = 0;
  int   result_count = 0;
  logic idle_on = 1'b0;

  // last range that a good set wrote, used to aim tests at set regions
  logic             have_set_range = 1'b0;
  logic [BIT_W-1:0] set_first = '0;
  logic [BIT_W-1:0] set_last = '0;

  bitmap_range_set_clear_test u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_first_bit (in_first_bit),
    .in_last_bit  (in_last_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("** bitmap_range_set_clear_test: FAILED **");
    $finish;
  end

  function automatic int length_in_use();
    return (shadow_len > MAX_BITS) ? MAX_BITS : int'(shadow_len);
  endfunction

  // update the shadow bit array and return the status the block should give
  function automatic logic apply_request(input logic [1:0] func,
                                         input logic [BIT_W-1:0] first_pos,
                                         input logic [BIT_W-1:0] last_pos);
    int limit;
    limit = length_in_use();
    if (int'(last_pos) >= limit || first_pos > last_pos || func == OP_UNKNOWN) begin
      return 1'b1;
    end
    for (int p = first_pos; p <= last_pos; p++) begin
      case (func)
        OP_SET: begin
          shadow_bits[p] = 1'b1;
        end
        OP_CLEAR: begin
          shadow_bits[p] = 1'b0;
        end
        default: begin
          if (!shadow_bits[p]) return 1'b1;
        end
      endcase
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    err_count++;
  endtask

  // one register write: setup cycle, then access cycle until pready
  task automatic write_bits_in_use(input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS_IN_USE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_len = value[LEN_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // send one request transaction, with an optional idle burst ahead of it
  task automatic send_request(input logic [1:0] func, input logic [BIT_W-1:0] first_pos,
                              input logic [BIT_W-1:0] last_pos);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_first_bit <= first_pos;
    in_last_bit  <= last_pos;
    do @(posedge clk); while (!in_ready);
    expected_status.push_back(apply_request(func, first_pos, last_pos));
  endtask

  // stop sending and wait until every expected result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
  endtask

  // result checking and receiver stalls
  initial begin
    int stall_left;
    logic want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", result_count));
        end else begin
          want = expected_status.pop_front();
          if (out_status !== want) begin
            report_mismatch($sformatf("result %0d: status %b, expected %b",
                                      result_count, out_status, want));
          end
        end
        result_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // extremes, byte boundaries, early test stop, bad ranges and unknown operation
  task automatic test_directed();
    send_request(OP_TEST, 12'd0, 12'd4095);
    send_request(OP_SET, 12'd0, 12'd0);
    send_request(OP_TEST, 12'd0, 12'd0);
    send_request(OP_SET, 12'd4095, 12'd4095);
    send_request(OP_TEST, 12'd4095, 12'd4095);
    send_request(OP_TEST, 12'd0, 12'd1);
    send_request(OP_SET, 12'd7, 12'd8);
    send_request(OP_TEST, 12'd7, 12'd8);
    send_request(OP_TEST, 12'd6, 12'd8);
    send_request(OP_SET, 12'd0, 12'd4095);
    send_request(OP_TEST, 12'd0, 12'd4095);
    send_request(OP_CLEAR, 12'd3, 12'd12);
    send_request(OP_TEST, 12'd0, 12'd2);
    send_request(OP_TEST, 12'd0, 12'd4095);
    send_request(OP_CLEAR, 12'd0, 12'd4095);
    send_request(OP_TEST, 12'd4095, 12'd4095);
    send_request(OP_SET, 12'd5, 12'd3);
    send_request(OP_TEST, 12'd4095, 12'd0);
    send_request(OP_UNKNOWN, 12'd0, 12'd0);
    send_request(OP_UNKNOWN, 12'd4095, 12'd4095);
    send_request(OP_CLEAR, 12'd100, 12'd100);
    send_request(OP_SET, 12'd1000, 12'd2047);
    send_request(OP_TEST, 12'd1000, 12'd2047);
    wait_for_results();
  endtask

  // zero, one, oversized and shrunk lengths; hidden bits come back when it grows
  task automatic test_length_setting();
    write_bits_in_use(32'd0);
    send_request(OP_SET, 12'd0, 12'd0);
    send_request(OP_TEST, 12'd0, 12'd0);
    wait_for_results();
    write_bits_in_use(32'd1);
    send_request(OP_SET, 12'd0, 12'd0);
    send_request(OP_SET, 12'd0, 12'd1);
    send_request(OP_TEST, 12'd0, 12'd0);
    wait_for_results();
    write_bits_in_use(32'd8191);
    send_request(OP_SET, 12'd4095, 12'd4095);
    send_request(OP_TEST, 12'd1000, 12'd2047);
    wait_for_results();
    // upper data bits lie outside the register
    write_bits_in_use(32'hFFFF_E064);
    send_request(OP_SET, 12'd99, 12'd99);
    send_request(OP_TEST, 12'd99, 12'd100);
    send_request(OP_TEST, 12'd4095, 12'd4095);
    wait_for_results();
    write_bits_in_use(32'd4096);
    send_request(OP_TEST, 12'd4095, 12'd4095);
    send_request(OP_CLEAR, 12'd0, 12'd4095);
    wait_for_results();
    write_bits_in_use(32'd4097);
    send_request(OP_SET, 12'd4094, 12'd4095);
    send_request(OP_TEST, 12'd4094, 12'd4095);
    wait_for_results();
  endtask

  // random requests over several length settings, mostly well-formed ranges
  task automatic test_random_requests();
    logic [1:0]       func;
    logic [BIT_W-1:0] first_pos;
    logic [BIT_W-1:0] last_pos;
    int limit;
    int span;
    int r;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_bits_in_use(32'd4096);
        1: write_bits_in_use(32'd8191);
        2: write_bits_in_use($urandom_range(1, 4095));
        3: write_bits_in_use(32'd4095);
        4: write_bits_in_use(32'd64);
        5: write_bits_in_use($urandom_range(0, 8191));
        6: write_bits_in_use(32'd1);
        default: write_bits_in_use(32'd4096);
      endcase
      idle_on = (phase != 3 && phase != NUM_PHASES - 1);
      limit = length_in_use();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10 || limit == 0) begin
          // noise: any field values
          func      = 2'($urandom_range(0, 3));
          first_pos = BIT_W'($urandom);
          last_pos  = BIT_W'($urandom);
        end else begin
          r = $urandom_range(0, 99);
          func = (r < 30) ? OP_SET : (r < 55) ? OP_CLEAR : (r < 97) ? OP_TEST : OP_UNKNOWN;
          if (func == OP_TEST && have_set_range && $urandom_range(0, 1) == 1) begin
            first_pos = BIT_W'($urandom_range(set_first, set_last));
            last_pos  = BIT_W'($urandom_range(first_pos, set_last));
          end else begin
            r = $urandom_range(0, 99);
            span = (r < 50) ? $urandom_range(0, 15) :
                   (r < 80) ? $urandom_range(0, 127) :
                   (r < 95) ? $urandom_range(0, 1023) : $urandom_range(0, limit - 1);
            if (span > limit - 1) span = limit - 1;
            first_pos = BIT_W'($urandom_range(0, limit - 1 - span));
            last_pos  = BIT_W'(int'(first_pos) + span);
          end
          if (func == OP_SET) begin
            have_set_range = 1'b1;
            set_first = first_pos;
            set_last  = last_pos;
          end
        end
        send_request(func, first_pos, last_pos);
      end
      wait_for_results();
    end
  endtask

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_length_setting();
    test_random_requests();
    repeat (16) @(posedge clk);
    if (expected_status.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_status.size()));
    end
    if (err_count == 0) begin
      $display("** bitmap_range_set_clear_test: PASSED **");
    end else begin
      $display("** bitmap_range_set_clear_test: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bmr_pkg.sv
hw/rtl/bmr_ram.sv
hw/rtl/bmr_dpath.sv
hw/rtl/bmr_ctrl.sv
hw/rtl/bitmap_range_set_clear_test.sv
test/bitmap_range_set_clear_test_tb.sv
